// ===== sv/dva_pkg.sv =====
// ----------------------------------------------------------------------------
// dva_pkg
// Shared constants, register indexes and the centimetre fraction table for
// the distance volume attenuator.
// ----------------------------------------------------------------------------
package dva_pkg;

  localparam int VOL_W   = 16;
  localparam int CFG_W   = 24;
  localparam int CURVE_W = 17;   // Q.16 curve value, max 1.0
  localparam int LN_W    = 19;
  localparam int RECIP_QW = 11;  // 2^32 / crossover fits 11 bits
  localparam int GAIN_QW  = 33;  // gain up to 2^32

  localparam logic [CURVE_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [21:0]        XOVER_Q16 = 22'd3305325;
  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;

  typedef enum logic {
    REG_ATTEN_EN = 1'b0,
    REG_DIRECT   = 1'b1
  } reg_idx_e;

  // floor((r * 16384 + 12) / 25) for r in 0..24
  function automatic logic [13:0] cm_frac(input logic [4:0] r);
    logic [13:0] v;
    case (r)
      5'd0:  v = 14'd0;
      5'd1:  v = 14'd655;
      5'd2:  v = 14'd1311;
      5'd3:  v = 14'd1966;
      5'd4:  v = 14'd2621;
      5'd5:  v = 14'd3277;
      5'd6:  v = 14'd3932;
      5'd7:  v = 14'd4588;
      5'd8:  v = 14'd5243;
      5'd9:  v = 14'd5898;
      5'd10: v = 14'd6554;
      5'd11: v = 14'd7209;
      5'd12: v = 14'd7864;
      5'd13: v = 14'd8520;
      5'd14: v = 14'd9175;
      5'd15: v = 14'd9830;
      5'd16: v = 14'd10486;
      5'd17: v = 14'd11141;
      5'd18: v = 14'd11796;
      5'd19: v = 14'd12452;
      5'd20: v = 14'd13107;
      5'd21: v = 14'd13763;
      5'd22: v = 14'd14418;
      5'd23: v = 14'd15073;
      5'd24: v = 14'd15729;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/distance_volume_attenuator_top.sv =====
// ----------------------------------------------------------------------------
// distance_volume_attenuator_top
// Scales each ray volume by the distance curve, normalized to the direct
// sound distance when enabled. Saturating Q4.12 output.
//
//   port group | direction | words
//   in_*       | in        | ray_distance_cm_i, ray_volume_i
//   out_*      | out       | attenuated_volume_o, saturated_o
//   cfg_*      | in        | register writes, no read-back
//
// One word per cycle while the output is not stalled. Pipeline stages: curve 21,
// gain path 35 (one quotient bit per stage over 33 bits), product 2.
// Reset clears valid flags and sets the configuration registers to their defaults.
// A stall on the output freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module distance_volume_attenuator_top
  import dva_pkg::*;
#(
  parameter int DIST_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [DIST_BITS-1:0] ray_distance_cm_i,
  input  logic [VOL_W-1:0]     ray_volume_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [VOL_W-1:0]     attenuated_volume_o,
  output logic                 saturated_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int CURVE_LAT = 21;
  localparam int GAIN_LAT  = GAIN_QW + 2;
  localparam int TOTAL_LAT = CURVE_LAT + GAIN_LAT + 2;

  logic en;
  assign en         = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // configuration
  logic             atten_en_q;
  logic [CFG_W-1:0] direct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atten_en_q <= 1'b1;
      direct_q   <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ATTEN_EN: atten_en_q <= cfg_wdata_i[0];
        REG_DIRECT:   direct_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  dva_dly #(.W(1), .N(TOTAL_LAT)) u_vld (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (in_valid_i),
    .q_o    (out_valid_o)
  );

  // curves
  logic [CURVE_W-1:0] f_ray;
  logic [CURVE_W-1:0] f_dir;

  dva_curve #(.DB(DIST_BITS)) u_curve_ray (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cm_i   (ray_distance_cm_i),
    .f_o    (f_ray)
  );

  dva_curve #(.DB(DIST_BITS)) u_curve_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .cm_i   (DIST_BITS'(direct_q)),
    .f_o    (f_dir)
  );

  // gain = round(2^32 / f_dir)
  logic [GAIN_QW-1:0] gnum_q;
  logic [CURVE_W-1:0] gden_q;
  logic [GAIN_QW-1:0] gquo;
  logic [GAIN_QW-1:0] g_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      gnum_q <= GAIN_QW'(64'd1 << 32) + GAIN_QW'(f_dir >> 1);
      gden_q <= f_dir;
    end
  end

  dva_div #(.NW(GAIN_QW), .DW(CURVE_W), .QW(GAIN_QW)) u_gain_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (gnum_q),
    .den_i (gden_q),
    .quo_o (gquo)
  );

  always_ff @(posedge clk_i) begin
    if (en) g_q <= atten_en_q ? gquo : GAIN_QW'(ONE_Q16);
  end

  // align ray curve and volume
  logic [CURVE_W-1:0] f_ray_dly;
  logic [VOL_W-1:0]   vol_dly;

  dva_dly #(.W(CURVE_W), .N(GAIN_LAT)) u_f_pad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (f_ray),
    .q_o    (f_ray_dly)
  );

  dva_dly #(.W(VOL_W), .N(CURVE_LAT + GAIN_LAT)) u_vol_pad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (ray_volume_i),
    .q_o    (vol_dly)
  );

  // combined factor
  logic [49:0] gf;
  logic [33:0] c_q;
  logic [VOL_W-1:0] vol_q;

  assign gf = 50'(g_q) * 50'(f_ray_dly) + 50'(1 << 15);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q   <= gf[49:16];
      vol_q <= vol_dly;
    end
  end

  // scaled volume with saturation
  logic [50:0] vc;
  logic [34:0] r;
  logic [VOL_W-1:0] out_vol_q;
  logic             sat_q;

  assign vc = 51'(vol_q) * 51'(c_q) + 51'(1 << 15);
  assign r  = vc[50:16];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (r[34:VOL_W] != '0) begin
        out_vol_q <= '1;
        sat_q     <= 1'b1;
      end else begin
        out_vol_q <= r[VOL_W-1:0];
        sat_q     <= 1'b0;
      end
    end
  end

  assign attenuated_volume_o = out_vol_q;
  assign saturated_o         = sat_q;

endmodule

// ===== sv/dva_dly.sv =====
// ----------------------------------------------------------------------------
// dva_dly
// Enable-gated delay line of fixed length.
// ----------------------------------------------------------------------------
module dva_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < N; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[N-1];

endmodule

// ===== sv/dva_div.sv =====
// ----------------------------------------------------------------------------
// dva_div
// Pipelined restoring divider, one quotient bit per stage.
// Requires num >> QW < den.
// ----------------------------------------------------------------------------
module dva_div #(
  parameter int NW = 35,
  parameter int DW = 34,
  parameter int QW = 11
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] nlow_q [QW];
  logic [DW-1:0] rem_in [QW];
  logic [DW-1:0] den_in [QW];
  logic [QW-1:0] nlow_in[QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;

    if (s == 0) begin : g_first
      assign rem_in[s]  = DW'(num_i >> QW);
      assign den_in[s]  = den_i;
      assign nlow_in[s] = num_i[QW-1:0];
    end else begin : g_next
      assign rem_in[s]  = rem_q[s-1];
      assign den_in[s]  = den_q[s-1];
      assign nlow_in[s] = nlow_q[s-1];
    end

    assign t    = {rem_in[s], nlow_in[s][QW-1]};
    assign ge   = t >= {1'b0, den_in[s]};
    assign diff = t - {1'b0, den_in[s]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        den_q[s]  <= den_in[s];
        nlow_q[s] <= {nlow_in[s][QW-2:0], ge};
      end
    end
  end

  assign quo_o = nlow_q[QW-1];

endmodule

// ===== sv/dva_ln.sv =====
// ----------------------------------------------------------------------------
// dva_ln
// Natural log in Q.16 for 1.0 <= d < 2^22 / 2^16: normalize, sixteen
// squaring stages for the log2 fraction, then scale by ln 2. 18 stages.
// ----------------------------------------------------------------------------
module dva_ln
  import dva_pkg::*;
#(
  parameter int DW = 34
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DW-1:0]   d_i,
  output logic [LN_W-1:0] ln_o
);

  logic [30:0]     m_q  [17];
  logic [LN_W-1:0] lg_q [17];
  logic [LN_W-1:0] ln_q;

  logic [21:0] d22;
  logic [4:0]  p;
  logic [35:0] shl;

  assign d22 = d_i[21:0];

  always_comb begin
    p = 5'd16;
    for (int b = 16; b <= 21; b++) begin
      if (d22[b]) p = 5'(b);
    end
    shl = 36'(d22) << (5'd30 - p);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]  <= shl[30:0];
      lg_q[0] <= {3'(p - 5'd16), 16'd0};
    end
  end

  for (genvar i = 1; i <= 16; i++) begin : g_sq
    localparam int B = 16 - i;
    logic [61:0] sq;
    logic [31:0] t;

    assign sq = 62'(m_q[i-1]) * 62'(m_q[i-1]);
    assign t  = sq[61:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (t[31]) begin
          m_q[i]  <= t[31:1];
          lg_q[i] <= lg_q[i-1] | (LN_W'(1) << B);
        end else begin
          m_q[i]  <= t[30:0];
          lg_q[i] <= lg_q[i-1];
        end
      end
    end
  end

  logic [50:0] lnp;
  assign lnp = 51'(lg_q[16]) * 51'(LN2_Q32) + 51'(64'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (en_i) ln_q <= lnp[50:32];
  end

  assign ln_o = ln_q;

endmodule

// ===== sv/dva_curve.sv =====
// ----------------------------------------------------------------------------
// dva_curve
// Distance in cm to attenuation curve in Q.16: cm to metres (2 stages),
// log and reciprocal branches in parallel (18 stages), select (1 stage).
// ----------------------------------------------------------------------------
module dva_curve
  import dva_pkg::*;
#(
  parameter int DB = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [DB-1:0]      cm_i,
  output logic [CURVE_W-1:0] f_o
);

  localparam int DW = DB + 10;
  localparam int NW = ((DW > 33) ? DW : 33) + 1;
  localparam int S  = DB + 5;
  localparam logic [DB:0] MAGIC = (DB+1)'((64'd1 << S) / 64'd25 + 64'd1);

  logic [2*DB:0] prod_q;
  logic [DB-1:0] cm_q;
  logic [DW-1:0] d_q;

  logic [DB-5:0] k;
  logic [DB-1:0] k25;
  logic [4:0]    r;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= (2*DB+1)'(cm_i) * (2*DB+1)'(MAGIC);
      cm_q   <= cm_i;
    end
  end

  assign k   = prod_q[2*DB:S];
  assign k25 = DB'(k) * DB'(25);
  assign r   = 5'(cm_q - k25);

  always_ff @(posedge clk_i) begin
    if (en_i) d_q <= {k, cm_frac(r)};
  end

  // log branch
  logic [LN_W-1:0] ln;

  dva_ln #(.DW(DW)) u_ln (
    .clk_i (clk_i),
    .en_i  (en_i),
    .d_i   (d_q),
    .ln_o  (ln)
  );

  // reciprocal branch
  logic [NW-1:0]       num_q;
  logic [DW-1:0]       den_q;
  logic [RECIP_QW-1:0] quo;
  logic [RECIP_QW-1:0] quo_dly;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= NW'(64'd1 << 32) + NW'(d_q >> 1);
      den_q <= d_q;
    end
  end

  dva_div #(.NW(NW), .DW(DW), .QW(RECIP_QW)) u_recip (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  dva_dly #(.W(RECIP_QW), .N(17 - RECIP_QW)) u_recip_pad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (quo),
    .q_o    (quo_dly)
  );

  // range class
  logic [1:0] cls;
  logic [1:0] cls_dly;

  assign cls[0] = (d_q >> 16) == '0;
  assign cls[1] = d_q < DW'(XOVER_Q16);

  dva_dly #(.W(2), .N(18)) u_cls_pad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .d_i    (cls),
    .q_o    (cls_dly)
  );

  logic [CURVE_W-1:0] f_q;
  logic [CURVE_W-1:0] f_ln;
  logic [LN_W:0]      ln_r;

  assign ln_r = (LN_W+1)'(ln) + (LN_W+1)'(2);
  assign f_ln = ONE_Q16 - CURVE_W'(ln_r >> 2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cls_dly[0]) begin
        f_q <= ONE_Q16;
      end else if (cls_dly[1]) begin
        f_q <= f_ln;
      end else if (quo_dly == '0) begin
        f_q <= CURVE_W'(1);
      end else begin
        f_q <= CURVE_W'(quo_dly);
      end
    end
  end

  assign f_o = f_q;

endmodule
